### rtl/core/exlex_pkg.sv
`timescale 1ns / 1ps

package exlex_pkg;

   // Token kinds as reported on the result channel.
   localparam logic [3:0] KIND_NUMBER    = 4'd0;
   localparam logic [3:0] KIND_IDENT     = 4'd1;
   localparam logic [3:0] KIND_LET       = 4'd2;
   localparam logic [3:0] KIND_PRINT     = 4'd3;
   localparam logic [3:0] KIND_EQUAL     = 4'd4;
   localparam logic [3:0] KIND_SEMICOLON = 4'd5;
   localparam logic [3:0] KIND_PLUS      = 4'd6;
   localparam logic [3:0] KIND_MINUS     = 4'd7;
   localparam logic [3:0] KIND_STAR      = 4'd8;
   localparam logic [3:0] KIND_SLASH     = 4'd9;
   localparam logic [3:0] KIND_LPAREN    = 4'd10;
   localparam logic [3:0] KIND_RPAREN    = 4'd11;
   localparam logic [3:0] KIND_END       = 4'd12;
   localparam logic [3:0] KIND_ERROR     = 4'd13;

   // Scanner state codes.
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_NUM  = 2'd1;
   localparam logic [1:0] MODE_WORD = 2'd2;
   localparam logic [1:0] MODE_ERR  = 2'd3;

   // Keyword tracking codes.
   localparam logic [1:0] KW_START = 2'd0;
   localparam logic [1:0] KW_LET   = 2'd1;
   localparam logic [1:0] KW_PRINT = 2'd2;
   localparam logic [1:0] KW_NONE  = 2'd3;

   localparam int LET_LEN   = 3;
   localparam int PRINT_LEN = 5;

   // One result as it leaves the block.
   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] value;
      logic        overflow;
      logic [15:0] start;
      logic [15:0] length;
      logic        last;
   } result_type;

   // Expected character of "let" at a given index.
   function automatic logic [7:0] let_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = "l";
         3'd1:    ch = "e";
         3'd2:    ch = "t";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Expected character of "print" at a given index.
   function automatic logic [7:0] print_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = "p";
         3'd1:    ch = "r";
         3'd2:    ch = "i";
         3'd3:    ch = "n";
         3'd4:    ch = "t";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Operator character to token kind; zero when the byte is no operator.
   function automatic logic [3:0] op_kind(input logic [7:0] ch);
      logic [3:0] kind;
      unique case (ch)
         "=":     kind = KIND_EQUAL;
         ";":     kind = KIND_SEMICOLON;
         "+":     kind = KIND_PLUS;
         "-":     kind = KIND_MINUS;
         "*":     kind = KIND_STAR;
         "/":     kind = KIND_SLASH;
         "(":     kind = KIND_LPAREN;
         ")":     kind = KIND_RPAREN;
         default: kind = KIND_NUMBER;
      endcase
      return kind;
   endfunction

endpackage

### rtl/core/expression_lexer.sv
`timescale 1ns / 1ps
// Results of a request are written to the result queue at the edge that accepts the request.
// Throughput: one request per cycle while each request yields at most one result and rsp_tready
// is high; a request that yields several results (up to three) holds the single result port longer.
// The 4-entry result queue sets the rate: requests are taken while it holds at most one result.
// Reset (synchronous, active high) empties the queue and returns the scanner to idle at offset 0.

module expression_lexer #(
   parameter int VALUE_WIDTH = 32,
   parameter int POS_WIDTH   = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tuser,   // [0] has_char
   input  logic        req_tlast,   // end_of_source
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] number_value, [32] value_overflow,
                                    // [48:33] token_start, [64:49] token_length, rest zero
   output logic [3:0]  rsp_tuser,   // [3:0] token_kind
   output logic        rsp_tlast    // last_in_run
);

   import exlex_pkg::*;

   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;
   localparam logic [POS_WIDTH-1:0]   POS_MAX   = '1;
   localparam int                     PROD_W    = VALUE_WIDTH + 4;

   // Scanner state.
   logic [1:0]             scan_mode_ff, scan_mode_in;
   logic [VALUE_WIDTH-1:0] number_accum_ff, number_accum_in;
   logic                   accum_overflow_ff, accum_overflow_in;
   logic [POS_WIDTH-1:0]   word_length_ff, word_length_in;
   logic [1:0]             keyword_match_ff, keyword_match_in;
   logic [POS_WIDTH-1:0]   char_position_ff, char_position_in;
   logic [POS_WIDTH-1:0]   run_start_ff, run_start_in;

   // Result queue.
   result_type queue_mem [4];
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [2:0] fifo_count_ff, fifo_count_in;

   logic       req_fire, rsp_fire;
   logic [7:0] ch;
   logic       has_char, end_src, active;
   logic       is_digit, is_alpha, is_space, is_op, is_other;
   logic [3:0] op_code;

   // Run state after the character, before any end-of-source handling.
   logic [1:0]             post_mode;
   logic [VALUE_WIDTH-1:0] post_accum;
   logic                   post_ovf;
   logic [POS_WIDTH-1:0]   post_len;
   logic [1:0]             post_kw;
   logic [POS_WIDTH-1:0]   post_start;
   logic [POS_WIDTH-1:0]   pos_next;

   logic [VALUE_WIDTH-1:0] base_accum;
   logic                   base_ovf;
   logic [POS_WIDTH-1:0]   base_len;
   logic [1:0]             base_kw;
   logic [POS_WIDTH-1:0]   base_start;
   logic [PROD_W-1:0]      accum_prod;
   logic [1:0]             kw_step;
   logic [POS_WIDTH-1:0]   len_step;

   // Candidate results in output order.
   result_type res_close1, res_op, res_close2, res_end;
   logic       v_close1, v_op, v_close2, v_end;
   logic [1:0] off_op, off_close2, off_end;
   logic [2:0] push_cnt;

   // Token for an open run.
   function automatic result_type run_token(input logic [1:0]             mode,
                                            input logic [VALUE_WIDTH-1:0] accum,
                                            input logic                   ovf,
                                            input logic [POS_WIDTH-1:0]   len,
                                            input logic [1:0]             kw,
                                            input logic [POS_WIDTH-1:0]   start);
      result_type r;
      logic [63:0] accum_ext;
      logic [31:0] len_ext;
      logic [31:0] start_ext;
      accum_ext = 64'(accum);
      len_ext   = 32'(len);
      start_ext = 32'(start);
      r.start   = start_ext[15:0];
      r.length  = len_ext[15:0];
      r.last    = 1'b0;
      if (mode == MODE_NUM) begin
         r.kind     = KIND_NUMBER;
         r.value    = accum_ext[31:0];
         r.overflow = ovf;
      end else begin
         r.value    = '0;
         r.overflow = 1'b0;
         if (kw == KW_LET && len == POS_WIDTH'(LET_LEN)) begin
            r.kind = KIND_LET;
         end else if (kw == KW_PRINT && len == POS_WIDTH'(PRINT_LEN)) begin
            r.kind = KIND_PRINT;
         end else begin
            r.kind = KIND_IDENT;
         end
      end
      return r;
   endfunction

   assign req_tready = (fifo_count_ff <= 3'd1);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = (fifo_count_ff != 3'd0);
   assign rsp_fire   = rsp_tvalid & rsp_tready;

   assign ch       = req_tdata;
   assign has_char = req_tuser;
   assign end_src  = req_tlast;
   assign active   = has_char && (scan_mode_ff != MODE_ERR);

   // Character classes.
   assign op_code  = op_kind(ch);
   assign is_digit = (ch >= "0") && (ch <= "9");
   assign is_alpha = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
   assign is_space = (ch == " ") || ((ch >= 8'd9) && (ch <= 8'd13));
   assign is_op    = (op_code != KIND_NUMBER);
   assign is_other = !is_digit && !is_alpha && !is_space && !is_op;

   // A character of a new kind starts its run from cleared values.
   always_comb begin
      if ((is_digit && scan_mode_ff == MODE_NUM) || (is_alpha && scan_mode_ff == MODE_WORD)) begin
         base_accum = number_accum_ff;
         base_ovf   = accum_overflow_ff;
         base_len   = word_length_ff;
         base_kw    = keyword_match_ff;
         base_start = run_start_ff;
      end else begin
         base_accum = '0;
         base_ovf   = 1'b0;
         base_len   = '0;
         base_kw    = KW_START;
         base_start = char_position_ff;
      end
   end

   // Decimal accumulate: value * 10 + digit, saturating when it no longer fits.
   assign accum_prod = ({4'b0, base_accum} << 3) + ({4'b0, base_accum} << 1)
                     + PROD_W'(ch[3:0]);
   assign len_step   = (base_len != POS_MAX) ? base_len + POS_WIDTH'(1) : base_len;

   // Keyword tracking on the word character at index base_len.
   always_comb begin
      kw_step = base_kw;
      unique case (base_kw)
         KW_START: begin
            if (ch == let_char(3'd0)) begin
               kw_step = KW_LET;
            end else if (ch == print_char(3'd0)) begin
               kw_step = KW_PRINT;
            end else begin
               kw_step = KW_NONE;
            end
         end
         KW_LET: begin
            if (base_len >= POS_WIDTH'(LET_LEN) || ch != let_char(base_len[2:0])) begin
               kw_step = KW_NONE;
            end
         end
         KW_PRINT: begin
            if (base_len >= POS_WIDTH'(PRINT_LEN) || ch != print_char(base_len[2:0])) begin
               kw_step = KW_NONE;
            end
         end
         default: kw_step = KW_NONE;
      endcase
   end

   // State after the character.
   always_comb begin
      post_mode  = scan_mode_ff;
      post_accum = number_accum_ff;
      post_ovf   = accum_overflow_ff;
      post_len   = word_length_ff;
      post_kw    = keyword_match_ff;
      post_start = run_start_ff;
      if (active) begin
         priority if (is_digit) begin
            post_mode  = MODE_NUM;
            post_start = base_start;
            post_kw    = base_kw;
            post_len   = len_step;
            if (accum_prod[PROD_W-1:VALUE_WIDTH] != 4'b0) begin
               post_accum = VALUE_MAX;
               post_ovf   = 1'b1;
            end else begin
               post_accum = accum_prod[VALUE_WIDTH-1:0];
               post_ovf   = base_ovf;
            end
         end else if (is_alpha) begin
            post_mode  = MODE_WORD;
            post_start = base_start;
            post_accum = base_accum;
            post_ovf   = base_ovf;
            post_kw    = kw_step;
            post_len   = len_step;
         end else if (is_other) begin
            post_mode = MODE_ERR;
         end else begin
            post_mode = MODE_IDLE;
         end
      end
   end

   assign pos_next = (has_char && char_position_ff != POS_MAX)
                   ? char_position_ff + POS_WIDTH'(1) : char_position_ff;

   // Candidate results.
   always_comb begin
      logic [31:0] pos_ext;
      logic [31:0] next_ext;
      pos_ext  = 32'(char_position_ff);
      next_ext = 32'(pos_next);

      v_close1 = active && (scan_mode_ff == MODE_NUM || scan_mode_ff == MODE_WORD)
               && !(is_digit && scan_mode_ff == MODE_NUM)
               && !(is_alpha && scan_mode_ff == MODE_WORD);
      res_close1 = run_token(scan_mode_ff, number_accum_ff, accum_overflow_ff,
                             word_length_ff, keyword_match_ff, run_start_ff);

      v_op            = active && (is_op || is_other);
      res_op.kind     = is_op ? op_code : KIND_ERROR;
      res_op.value    = is_op ? 32'd0 : 32'(ch);
      res_op.overflow = 1'b0;
      res_op.start    = pos_ext[15:0];
      res_op.length   = 16'd1;
      res_op.last     = 1'b0;

      v_close2   = end_src && (post_mode == MODE_NUM || post_mode == MODE_WORD);
      res_close2 = run_token(post_mode, post_accum, post_ovf, post_len, post_kw, post_start);

      v_end            = end_src && (post_mode != MODE_ERR);
      res_end.kind     = KIND_END;
      res_end.value    = '0;
      res_end.overflow = 1'b0;
      res_end.start    = next_ext[15:0];
      res_end.length   = '0;
      res_end.last     = 1'b1;

      // Mark the final result of this request.
      res_close2.last = !v_end;
      res_op.last     = !v_close2 && !v_end;
      res_close1.last = !v_op && !v_close2 && !v_end;
   end

   // Queue slots for the candidates, packed without gaps.
   assign off_op     = 2'(v_close1);
   assign off_close2 = off_op + 2'(v_op);
   assign off_end    = off_close2 + 2'(v_close2);
   assign push_cnt   = 3'(v_close1) + 3'(v_op) + 3'(v_close2) + 3'(v_end);

   // Next scanner state; end of source starts a new text at offset 0.
   always_comb begin
      scan_mode_in      = scan_mode_ff;
      number_accum_in   = number_accum_ff;
      accum_overflow_in = accum_overflow_ff;
      word_length_in    = word_length_ff;
      keyword_match_in  = keyword_match_ff;
      char_position_in  = char_position_ff;
      run_start_in      = run_start_ff;
      if (req_fire) begin
         if (end_src) begin
            scan_mode_in      = MODE_IDLE;
            number_accum_in   = '0;
            accum_overflow_in = 1'b0;
            word_length_in    = '0;
            keyword_match_in  = KW_START;
            char_position_in  = '0;
            run_start_in      = '0;
         end else begin
            scan_mode_in      = post_mode;
            number_accum_in   = post_accum;
            accum_overflow_in = post_ovf;
            word_length_in    = post_len;
            keyword_match_in  = post_kw;
            char_position_in  = pos_next;
            run_start_in      = post_start;
         end
      end
   end

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      fifo_count_in = fifo_count_ff;
      if (req_fire) begin
         wr_ptr_in     = wr_ptr_ff + push_cnt[1:0];
         fifo_count_in = fifo_count_in + push_cnt;
      end
      if (rsp_fire) begin
         rd_ptr_in     = rd_ptr_ff + 2'd1;
         fifo_count_in = fifo_count_in - 3'd1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_mode_ff      <= MODE_IDLE;
         number_accum_ff   <= '0;
         accum_overflow_ff <= 1'b0;
         word_length_ff    <= '0;
         keyword_match_ff  <= KW_START;
         char_position_ff  <= '0;
         run_start_ff      <= '0;
         wr_ptr_ff         <= '0;
         rd_ptr_ff         <= '0;
         fifo_count_ff     <= '0;
      end else begin
         scan_mode_ff      <= scan_mode_in;
         number_accum_ff   <= number_accum_in;
         accum_overflow_ff <= accum_overflow_in;
         word_length_ff    <= word_length_in;
         keyword_match_ff  <= keyword_match_in;
         char_position_ff  <= char_position_in;
         run_start_ff      <= run_start_in;
         wr_ptr_ff         <= wr_ptr_in;
         rd_ptr_ff         <= rd_ptr_in;
         fifo_count_ff     <= fifo_count_in;
      end
   end

   // Result queue storage.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (v_close1) begin
            queue_mem[wr_ptr_ff] <= res_close1;
         end
         if (v_op) begin
            queue_mem[wr_ptr_ff + off_op] <= res_op;
         end
         if (v_close2) begin
            queue_mem[wr_ptr_ff + off_close2] <= res_close2;
         end
         if (v_end) begin
            queue_mem[wr_ptr_ff + off_end] <= res_end;
         end
      end
   end

   // Result port.
   always_comb begin
      result_type head;
      head      = queue_mem[rd_ptr_ff];
      rsp_tdata = {7'b0, head.length, head.start, head.overflow, head.value};
      rsp_tuser = head.kind;
      rsp_tlast = head.last;
   end

   // The queue never holds more than its four entries.
   assert property (@(posedge clock) disable iff (reset) fifo_count_ff <= 3'd4)
      else $error("result queue overfilled");

   // While dropping after an error, a request that does not end the text yields nothing.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && scan_mode_ff == MODE_ERR && !req_tlast) |-> (push_cnt == 3'd0))
      else $error("result produced while dropping input");

   // End of source returns the scanner to idle at offset 0.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> (scan_mode_ff == MODE_IDLE && char_position_ff == '0))
      else $error("scanner not reset after end of source");

   // A request is never accepted when the queue cannot take all of its results.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (fifo_count_ff + push_cnt <= 3'd4))
      else $error("request accepted without queue room");

endmodule

### bench/tb_expression_lexer.sv
`timescale 1ns / 1ps

module tb_expression_lexer;
   import exlex_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 65;
   localparam int PRESSURE_ITEMS = 40;

   localparam logic [63:0] VALUE_MAX = 64'hFFFF_FFFF;
   localparam logic [15:0] POS_MAX = 16'hFFFF;
   localparam logic [23:0] LET_TEXT = "let";
   localparam logic [39:0] PRINT_TEXT = "print";
   localparam logic [7:0] CH_TAB = 8'd9;
   localparam logic [7:0] CH_CR = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;

   typedef enum logic [2:0] {
      BC_DIGIT, BC_ALPHA, BC_SPACE, BC_OPER, BC_OTHER
   } byte_class_type;

   // One request: source byte, has_char and end_of_source.
   typedef struct packed {
      logic [7:0] code;
      logic       has_char;
      logic       end_mark;
   } lex_item_type;

   // A directed row; typed rows carry their single result in place.
   typedef struct packed {
      lex_item_type item;
      logic         typed;
      logic [3:0]   kind;
      logic [31:0]  value;
      logic [15:0]  start;
      logic [15:0]  length;
   } table_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;

   // Scanner state of the predictor.
   logic [1:0]  sc_mode;
   logic [31:0] sc_accum;
   logic        sc_ovf;
   logic [15:0] sc_len;
   logic [1:0]  sc_kw;
   logic [15:0] sc_pos;
   logic [15:0] sc_start;

   result_type   pending_tokens[$];
   result_type   item_tokens[$];
   lex_item_type source_items[$];

   int mismatch_count = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;
   bit hold_request = 1'b0;

   table_row_type directed_rows [23] = '{
      '{'{"=", 1'b1, 1'b0}, 1'b1, KIND_EQUAL,     32'd0,   16'd0, 16'd1},
      '{'{";", 1'b1, 1'b0}, 1'b1, KIND_SEMICOLON, 32'd0,   16'd1, 16'd1},
      '{'{"+", 1'b1, 1'b0}, 1'b1, KIND_PLUS,      32'd0,   16'd2, 16'd1},
      '{'{"-", 1'b1, 1'b0}, 1'b1, KIND_MINUS,     32'd0,   16'd3, 16'd1},
      '{'{"*", 1'b1, 1'b0}, 1'b1, KIND_STAR,      32'd0,   16'd4, 16'd1},
      '{'{"/", 1'b1, 1'b0}, 1'b1, KIND_SLASH,     32'd0,   16'd5, 16'd1},
      '{'{"(", 1'b1, 1'b0}, 1'b1, KIND_LPAREN,    32'd0,   16'd6, 16'd1},
      '{'{")", 1'b1, 1'b0}, 1'b1, KIND_RPAREN,    32'd0,   16'd7, 16'd1},
      '{'{"p", 1'b1, 1'b0}, 1'b0, KIND_NUMBER,    32'd0,   16'd0, 16'd0},
      '{'{"r", 1'b1, 1'b0}, 1'b0, KIND_NUMBER,    32'd0,   16'd0, 16'd0},
      '{'{"i", 1'b1, 1'b0}, 1'b0, KIND_NUMBER,    32'd0,   16'd0, 16'd0},
      '{'{"n", 1'b1, 1'b0}, 1'b0, KIND_NUMBER,    32'd0,   16'd0, 16'd0},
      '{'{"t", 1'b1, 1'b0}, 1'b0, KIND_NUMBER,    32'd0,   16'd0, 16'd0},
      '{'{"9", 1'b1, 1'b0}, 1'b0, KIND_NUMBER,    32'd0,   16'd0, 16'd0},
      '{'{8'h00, 1'b0, 1'b0}, 1'b0, KIND_NUMBER,  32'd0,   16'd0, 16'd0},
      '{'{"l", 1'b1, 1'b0}, 1'b0, KIND_NUMBER,    32'd0,   16'd0, 16'd0},
      '{'{"e", 1'b1, 1'b0}, 1'b0, KIND_NUMBER,    32'd0,   16'd0, 16'd0},
      '{'{"t", 1'b1, 1'b0}, 1'b0, KIND_NUMBER,    32'd0,   16'd0, 16'd0},
      '{'{"+", 1'b1, 1'b1}, 1'b0, KIND_NUMBER,    32'd0,   16'd0, 16'd0},
      '{'{8'hFF, 1'b1, 1'b0}, 1'b1, KIND_ERROR,   32'd255, 16'd0, 16'd1},
      '{'{"a", 1'b1, 1'b0}, 1'b0, KIND_NUMBER,    32'd0,   16'd0, 16'd0},
      '{'{8'h00, 1'b0, 1'b1}, 1'b0, KIND_NUMBER,  32'd0,   16'd0, 16'd0},
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, KIND_END,     32'd0,   16'd0, 16'd0}
   };

   expression_lexer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Operator byte to its token kind; KIND_NUMBER when it is no operator.
   function automatic logic [3:0] operator_token(input logic [7:0] c);
      case (c)
         "=":     return KIND_EQUAL;
         ";":     return KIND_SEMICOLON;
         "+":     return KIND_PLUS;
         "-":     return KIND_MINUS;
         "*":     return KIND_STAR;
         "/":     return KIND_SLASH;
         "(":     return KIND_LPAREN;
         ")":     return KIND_RPAREN;
         default: return KIND_NUMBER;
      endcase
   endfunction

   function automatic byte_class_type classify_byte(input logic [7:0] c);
      if (c >= "0" && c <= "9") return BC_DIGIT;
      if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return BC_ALPHA;
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return BC_SPACE;
      if (operator_token(c) != KIND_NUMBER) return BC_OPER;
      return BC_OTHER;
   endfunction

   function automatic void clear_scanner();
      sc_mode = MODE_IDLE;
      sc_accum = '0;
      sc_ovf = 1'b0;
      sc_len = '0;
      sc_kw = KW_START;
      sc_pos = '0;
      sc_start = '0;
   endfunction

   function automatic void emit_token(input logic [3:0] kind, input logic [31:0] value,
                                      input logic ovf, input logic [15:0] start,
                                      input logic [15:0] length);
      result_type tok;
      tok.kind = kind;
      tok.value = value;
      tok.overflow = ovf;
      tok.start = start;
      tok.length = length;
      tok.last = 1'b0;
      item_tokens = {item_tokens, tok};
   endfunction

   // Close a number or word run, giving its token.
   function automatic void close_open_run();
      logic [3:0] kind;
      if (sc_mode == MODE_NUM) begin
         emit_token(KIND_NUMBER, sc_accum, sc_ovf, sc_start, sc_len);
      end else if (sc_mode == MODE_WORD) begin
         kind = KIND_IDENT;
         if (sc_kw == KW_LET && sc_len == 16'(LET_LEN)) kind = KIND_LET;
         else if (sc_kw == KW_PRINT && sc_len == 16'(PRINT_LEN)) kind = KIND_PRINT;
         emit_token(kind, 32'd0, 1'b0, sc_start, sc_len);
      end
      if (sc_mode != MODE_ERR) sc_mode = MODE_IDLE;
   endfunction

   function automatic void open_run(input logic [1:0] mode);
      sc_mode = mode;
      sc_start = sc_pos;
      sc_len = '0;
      sc_accum = '0;
      sc_ovf = 1'b0;
      sc_kw = KW_START;
   endfunction

   // Lexes one request and leaves the results it causes in item_tokens.
   function automatic void lex_char(input logic [7:0] c, input logic has, input logic eos);
      logic [63:0] digit;
      int idx;
      item_tokens.delete();
      digit = 64'(c) - 64'(8'("0"));
      if (has && sc_mode != MODE_ERR) begin
         case (classify_byte(c))
            BC_DIGIT: begin
               if (sc_mode != MODE_NUM) begin
                  close_open_run();
                  open_run(MODE_NUM);
               end
               if ({32'd0, sc_accum} > (VALUE_MAX - digit) / 64'd10) begin
                  sc_accum = '1;
                  sc_ovf = 1'b1;
               end else begin
                  sc_accum = sc_accum * 32'd10 + digit[31:0];
               end
               if (sc_len != POS_MAX) sc_len = sc_len + 16'd1;
            end
            BC_ALPHA: begin
               if (sc_mode != MODE_WORD) begin
                  close_open_run();
                  open_run(MODE_WORD);
               end
               idx = int'(sc_len);
               // Track whether the word can still become a keyword.
               case (sc_kw)
                  KW_START: begin
                     if (c == "l") sc_kw = KW_LET;
                     else if (c == "p") sc_kw = KW_PRINT;
                     else sc_kw = KW_NONE;
                  end
                  KW_LET: begin
                     if (idx >= LET_LEN) sc_kw = KW_NONE;
                     else if (c != LET_TEXT[8 * (LET_LEN - 1 - idx) +: 8]) sc_kw = KW_NONE;
                  end
                  KW_PRINT: begin
                     if (idx >= PRINT_LEN) sc_kw = KW_NONE;
                     else if (c != PRINT_TEXT[8 * (PRINT_LEN - 1 - idx) +: 8]) sc_kw = KW_NONE;
                  end
                  default: ;
               endcase
               if (sc_len != POS_MAX) sc_len = sc_len + 16'd1;
            end
            BC_SPACE: close_open_run();
            BC_OPER: begin
               close_open_run();
               emit_token(operator_token(c), 32'd0, 1'b0, sc_pos, 16'd1);
            end
            default: begin
               close_open_run();
               emit_token(KIND_ERROR, {24'd0, c}, 1'b0, sc_pos, 16'd1);
               sc_mode = MODE_ERR;
            end
         endcase
      end
      if (has && sc_pos != POS_MAX) sc_pos = sc_pos + 16'd1;
      // End of source: close, give END unless an error was seen, then start over.
      if (eos) begin
         if (sc_mode != MODE_ERR) begin
            close_open_run();
            emit_token(KIND_END, 32'd0, 1'b0, sc_pos, 16'd0);
         end
         clear_scanner();
      end
      if (item_tokens.size() > 0) item_tokens[item_tokens.size() - 1].last = 1'b1;
   endfunction

   function automatic void push_char(input logic [7:0] c);
      lex_item_type it;
      it.code = c;
      it.has_char = 1'b1;
      it.end_mark = 1'b0;
      source_items = {source_items, it};
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endfunction

   // Builds one source text: mostly well-formed tokens, some noise and errors.
   function automatic void build_source();
      string ops;
      string text;
      int pick;
      logic [7:0] c;
      lex_item_type it;
      ops = "=;+-*/()";
      source_items.delete();
      repeat ($urandom_range(1, 8)) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            case ($urandom_range(0, 7))
               0: text = "4294967295";
               1: text = "4294967296";
               2: text = $sformatf("%0d", $urandom);
               3: begin
                  text = "";
                  repeat ($urandom_range(10, 13)) text = {text, "9"};
               end
               4: text = $sformatf("0%0d", $urandom_range(0, 99));
               default: text = $sformatf("%0d", $urandom_range(0, 999));
            endcase
            push_text(text);
         end else if (pick < 55) begin
            case ($urandom_range(0, 11))
               0: push_text("let");
               1: push_text("print");
               2: push_text("le");
               3: push_text("lets");
               4: push_text("prin");
               5: push_text("printf");
               6: push_text("Let");
               7: push_text("plet");
               default: begin
                  repeat ($urandom_range(1, 6)) begin
                     c = 8'($urandom_range(0, 25));
                     push_char($urandom_range(0, 1) ? c + 8'("a") : c + 8'("A"));
                  end
               end
            endcase
         end else if (pick < 75) begin
            push_char(ops[$urandom_range(0, 7)]);
         end else if (pick < 88) begin
            repeat ($urandom_range(1, 2)) begin
               c = 8'($urandom_range(0, 5));
               push_char(c == 8'd5 ? CH_SPACE : CH_TAB + c);
            end
         end else if (pick < 97) begin
            it.code = 8'($urandom_range(0, 255));
            it.has_char = 1'b0;
            it.end_mark = 1'b0;
            source_items = {source_items, it};
         end else begin
            // A stray byte, then a few bytes that are dropped until the end.
            do c = 8'($urandom_range(0, 255)); while (classify_byte(c) != BC_OTHER);
            push_char(c);
            repeat ($urandom_range(0, 3)) push_char(8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 2) == 0) begin
         it.code = 8'($urandom_range(0, 255));
         it.has_char = 1'b0;
         it.end_mark = 1'b1;
         source_items = {source_items, it};
      end else begin
         source_items[source_items.size() - 1].end_mark = 1'b1;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   // Offers one request and predicts its results once it is certain to be taken.
   task automatic send_item(input lex_item_type it, input logic typed, input result_type fixed);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= it.code;
      req_tuser <= it.has_char;
      req_tlast <= it.end_mark;
      do @(negedge clock); while (req_tready !== 1'b1);
      lex_char(it.code, it.has_char, it.end_mark);
      if (typed) begin
         item_tokens.delete();
         item_tokens = {item_tokens, fixed};
      end
      pending_tokens = {pending_tokens, item_tokens};
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Each result taken at the coming edge is compared with the oldest prediction.
   always @(negedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_tokens.size() == 0) begin
            report_mismatch($sformatf("result kind %0d with nothing pending", rsp_tuser));
         end else begin
            want = pending_tokens.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch($sformatf("kind %0d, want %0d", rsp_tuser, want.kind));
            if (rsp_tdata[31:0] !== want.value)
               report_mismatch($sformatf("value %0d, want %0d", rsp_tdata[31:0], want.value));
            if (rsp_tdata[32] !== want.overflow)
               report_mismatch($sformatf("overflow %b, want %b", rsp_tdata[32], want.overflow));
            if (rsp_tdata[48:33] !== want.start)
               report_mismatch($sformatf("start %0d, want %0d", rsp_tdata[48:33], want.start));
            if (rsp_tdata[64:49] !== want.length)
               report_mismatch($sformatf("length %0d, want %0d", rsp_tdata[64:49],
                                         want.length));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last %b, want %b", rsp_tlast, want.last));
            if (rsp_tdata[71:65] !== 7'd0)
               report_mismatch($sformatf("padding bits %h not zero", rsp_tdata[71:65]));
         end
      end
   end

   // Watchdog on cycles in which neither channel moves anything.
   always @(negedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("expression_lexer verification failed");
               $finish;
            end
         end
      end
   end

   initial begin
      result_type fixed;
      int counted;
      clear_scanner();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows: operators, keywords, a bare item, a three-result end, errors.
      foreach (directed_rows[i]) begin
         fixed.kind = directed_rows[i].kind;
         fixed.value = directed_rows[i].value;
         fixed.overflow = 1'b0;
         fixed.start = directed_rows[i].start;
         fixed.length = directed_rows[i].length;
         fixed.last = 1'b1;
         send_item(directed_rows[i].item, directed_rows[i].typed, fixed);
      end
      wait_drained();

      // Random sources under four idling patterns.
      fixed = '0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            build_source();
            foreach (source_items[j]) begin
               send_item(source_items[j], 1'b0, fixed);
               if (source_items[j].has_char || source_items[j].end_mark) counted++;
            end
         end
         wait_drained();
      end

      // Receiver holds off while requests keep coming, so the block backs up.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 1'b1;
      counted = 0;
      while (counted < PRESSURE_ITEMS) begin
         build_source();
         foreach (source_items[j]) begin
            send_item(source_items[j], 1'b0, fixed);
            if (source_items[j].has_char || source_items[j].end_mark) counted++;
         end
      end
      wait_drained();

      repeat (8) @(posedge clock);
      if (pending_tokens.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_tokens.size()));
      if (mismatch_count == 0) begin
         $display("expression_lexer verification clean");
      end else begin
         $display("expression_lexer verification failed");
      end
      $finish;
   end

endmodule

### expression_lexer.f
rtl/core/exlex_pkg.sv
rtl/core/expression_lexer.sv
bench/tb_expression_lexer.sv
